@@ rtl/tach_pkg.sv @@
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types, constants and codes of the capture period tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

  // channel set and field widths
  localparam int CHANNELS   = 3;
  localparam int CH_W       = 2;
  localparam int CAP_W      = 32;
  localparam int PERIOD_W   = 32;
  localparam int MS_W       = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  // iterative divider
  localparam int DIV_W      = 48;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  // job queue between front and back (depth is a power of two)
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // result field widths
  localparam int FREQ_W     = 37;
  localparam int SPEED_W    = 28;
  localparam int RPM_W      = 16;

  // the engine channel; lower channels are wheels
  localparam logic [CH_W-1:0] ENGINE_CH = 2'd2;

  // scale factors: speed = clk*circ*9 / (p*teeth*25), rpm = clk*60 / (p*ppr)
  localparam logic [5:0] WHEEL_NUM_K  = 6'd9;
  localparam logic [5:0] ENGINE_NUM_K = 6'd60;
  localparam logic [4:0] WHEEL_DEN_K  = 5'd25;
  localparam logic [4:0] ENGINE_DEN_K = 5'd1;

  // register reset values
  localparam logic [28:0] RST_TIMER_CLOCK_HZ   = 29'd96000000;
  localparam logic [15:0] RST_SIGNAL_TIMEOUT   = 16'd500;
  localparam logic [15:0] RST_WHEEL_HZ_LIMIT   = 16'd1000;
  localparam logic [7:0]  RST_WHEEL_TEETH      = 8'd20;
  localparam logic [12:0] RST_WHEEL_CIRC_MM    = 13'd1600;
  localparam logic [4:0]  RST_ENGINE_PPR       = 5'd1;
  localparam logic [15:0] RST_RPM_LIMIT        = 16'd20000;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_QUERY   = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_CLOCK_HZ    = 3'd0,
    CFG_SIGNAL_TIMEOUT_MS = 3'd1,
    CFG_WHEEL_HZ_LIMIT    = 3'd2,
    CFG_WHEEL_TEETH       = 3'd3,
    CFG_WHEEL_CIRC_MM     = 3'd4,
    CFG_ENGINE_PPR        = 3'd5,
    CFG_RPM_LIMIT         = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_NUM,
    BK_MUL_DEN,
    BK_MUL_LIM,
    BK_SCALE,
    BK_START,
    BK_WAIT,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic [28:0] timer_clock_hz;
    logic [15:0] signal_timeout_ms;
    logic [15:0] wheel_hz_limit;
    logic [7:0]  wheel_teeth;
    logic [12:0] wheel_circumference_mm;
    logic [4:0]  crank_pulses;
    logic [15:0] rpm_limit;
  } cfg_t;

  // one query that passed the timeout and period checks
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [PERIOD_W-1:0] period;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/tach_fifo.sv @@
// ----------------------------------------------------------------------------
// tach_fifo
// Short job queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module tach_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tach_pkg::job_t    job_i,
  input  logic              pop_i,
  output tach_pkg::job_t    job_o,
  output logic              valid_o,
  output logic              full_o
);

  tach_pkg::job_t                          mem_q [tach_pkg::FIFO_DEPTH];
  logic [tach_pkg::FIFO_PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [tach_pkg::FIFO_CNT_W-1:0]         count_q, count_d;
  logic                                    do_push, do_pop;

  assign full_o  = (count_q == tach_pkg::FIFO_CNT_W'(tach_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // occupancy
  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

@@ rtl/tach_front.sv @@
// ----------------------------------------------------------------------------
// tach_front
// Takes input transfers, keeps per-channel capture state and turns live
// queries into jobs for the back end.
// ----------------------------------------------------------------------------
module tach_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [tach_pkg::CH_W-1:0]       channel_i,
  input  logic [31:0]                     capture_value_i,
  input  logic [tach_pkg::MS_W-1:0]       now_ms_i,
  input  logic [15:0]                     timeout_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output tach_pkg::job_t                  job_o
);

  logic [tach_pkg::CAP_W-1:0]    prev_cap_q   [tach_pkg::CHANNELS];
  logic [tach_pkg::PERIOD_W-1:0] period_q     [tach_pkg::CHANNELS];
  logic [tach_pkg::MS_W-1:0]     last_ms_q    [tach_pkg::CHANNELS];

  logic                          accept;
  logic                          ch_ok;
  logic                          is_capture;
  logic [tach_pkg::CAP_W-1:0]    cap;
  logic [tach_pkg::PERIOD_W-1:0] sel_period;
  logic [tach_pkg::MS_W-1:0]     sel_last_ms;
  logic [tach_pkg::MS_W-1:0]     elapsed;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign ch_ok      = (int'(channel_i) < tach_pkg::CHANNELS);
  assign is_capture = (tach_pkg::mode_e'(mode_i) == tach_pkg::MODE_CAPTURE);
  assign cap        = capture_value_i[tach_pkg::CAP_W-1:0];

  // state of the addressed channel
  always_comb begin
    sel_period  = '0;
    sel_last_ms = '0;
    for (int i = 0; i < tach_pkg::CHANNELS; i++) begin
      if (int'(channel_i) == i) begin
        sel_period  = period_q[i];
        sel_last_ms = last_ms_q[i];
      end
    end
  end

  // a query is live while its channel saw an edge recently and has a period
  assign elapsed = now_ms_i - sel_last_ms;
  assign push_o  = accept && ch_ok && !is_capture &&
                   (elapsed <= {16'b0, timeout_i}) && (sel_period != '0);
  assign job_o.ch     = channel_i;
  assign job_o.period = sel_period;

  // capture events update the channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tach_pkg::CHANNELS; i++) begin
        prev_cap_q[i] <= '0;
        period_q[i]   <= '0;
        last_ms_q[i]  <= '0;
      end
    end else if (accept && is_capture) begin
      for (int i = 0; i < tach_pkg::CHANNELS; i++) begin
        if (int'(channel_i) == i) begin
          if (prev_cap_q[i] != '0) begin
            period_q[i] <= tach_pkg::PERIOD_W'(cap - prev_cap_q[i]);
          end
          prev_cap_q[i] <= cap;
          last_ms_q[i]  <= now_ms_i;
        end
      end
    end
  end

endmodule

@@ rtl/tach_div.sv @@
// ----------------------------------------------------------------------------
// tach_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tach_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tach_pkg::DIV_W-1:0]    dividend_i,
  input  logic [tach_pkg::DIV_W-1:0]    divisor_i,
  output tach_pkg::div_stat_t           stat_o,
  output logic [tach_pkg::DIV_W-1:0]    quotient_o
);

  logic                             busy_q, done_q;
  logic [tach_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [tach_pkg::DIV_W-1:0]       rem_q, quo_q, dsr_q;
  logic [tach_pkg::DIV_W:0]         shifted;
  logic [tach_pkg::DIV_W+1:0]       diff;
  logic                             ge;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem_q, quo_q[tach_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dsr_q};
  assign ge      = !diff[tach_pkg::DIV_W+1];

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == tach_pkg::DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= tach_pkg::DIV_CNT_W'(tach_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tach_pkg::DIV_CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tach_pkg::DIV_W-1:0] : shifted[tach_pkg::DIV_W-1:0];
      quo_q <= {quo_q[tach_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

@@ rtl/tach_back.sv @@
// ----------------------------------------------------------------------------
// tach_back
// Turns a queued period into frequency, wheel speed or engine rpm and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tach_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tach_pkg::cfg_t                   cfg_i,
  input  logic                             job_valid_i,
  input  tach_pkg::job_t                   job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tach_pkg::CH_W-1:0]        channel_out_o,
  output logic                             signal_present_o,
  output logic [tach_pkg::FREQ_W-1:0]      frequency_q8_o,
  output logic [tach_pkg::SPEED_W-1:0]     wheel_speed_centi_kph_o,
  output logic [tach_pkg::RPM_W-1:0]       engine_rpm_o
);

  tach_pkg::back_state_e             state_q, state_d;

  logic [tach_pkg::CH_W-1:0]         ch_q;
  logic [tach_pkg::PERIOD_W-1:0]     p_q;
  logic [41:0]                       num_q;
  logic [39:0]                       den_q;
  logic [47:0]                       lim_q;
  logic [tach_pkg::DIV_W-1:0]        num_s_q, den_s_q;
  logic                              over_q;

  logic                              wheel;
  logic [7:0]                        teeth_eff;
  logic [4:0]                        ppr_eff;
  logic [12:0]                       fac_a;
  logic [7:0]                        fac_b;
  logic [5:0]                        k_num;
  logic [4:0]                        k_den;
  logic [41:0]                       num_prod;
  logic [39:0]                       den_prod;
  logic [47:0]                       lim_prod;
  logic [tach_pkg::DIV_W-1:0]        num_sc, den_sc;

  logic                              div_start;
  tach_pkg::div_stat_t               freq_stat, aux_stat;
  logic [tach_pkg::DIV_W-1:0]        freq_quo, aux_quo;

  logic                              out_free, load_out;
  logic                              res_present;
  logic [tach_pkg::FREQ_W-1:0]       res_freq;
  logic [tach_pkg::SPEED_W-1:0]      res_speed;
  logic [tach_pkg::RPM_W-1:0]        res_rpm;
  logic                              out_valid_q;

  // operand selection per channel kind; zero divisor registers act as one
  assign wheel     = (ch_q != tach_pkg::ENGINE_CH);
  assign teeth_eff = (cfg_i.wheel_teeth == '0) ? 8'd1 : cfg_i.wheel_teeth;
  assign ppr_eff   = (cfg_i.crank_pulses == '0) ? 5'd1
                                                 : cfg_i.crank_pulses;
  assign fac_a     = wheel ? cfg_i.wheel_circumference_mm : 13'd1;
  assign fac_b     = wheel ? teeth_eff : {3'b0, ppr_eff};
  assign k_num     = wheel ? tach_pkg::WHEEL_NUM_K : tach_pkg::ENGINE_NUM_K;
  assign k_den     = wheel ? tach_pkg::WHEEL_DEN_K : tach_pkg::ENGINE_DEN_K;

  // one product per multiply step; the scale step forms two
  assign num_prod = {13'b0, cfg_i.timer_clock_hz} * {29'b0, fac_a};
  assign den_prod = {8'b0, p_q} * {32'b0, fac_b};
  assign lim_prod = {16'b0, p_q} * {32'b0, cfg_i.wheel_hz_limit};
  assign num_sc   = {6'b0, num_q} * {42'b0, k_num};
  assign den_sc   = {8'b0, den_q} * {43'b0, k_den};

  // frequency and speed/rpm quotients run side by side
  tach_div u_div_freq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({11'b0, cfg_i.timer_clock_hz, 8'b0}),
    .divisor_i  ({16'b0, p_q}),
    .stat_o     (freq_stat),
    .quotient_o (freq_quo)
  );

  tach_div u_div_aux (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_s_q),
    .divisor_i  (den_s_q),
    .stat_o     (aux_stat),
    .quotient_o (aux_quo)
  );

  // limit checks and final fields
  always_comb begin
    res_freq    = freq_quo[tach_pkg::FREQ_W-1:0];
    res_speed   = '0;
    res_rpm     = '0;
    res_present = 1'b0;
    if (wheel) begin
      if (over_q) begin
        res_freq = '0;
      end else begin
        res_speed   = aux_quo[tach_pkg::SPEED_W-1:0];
        res_present = (aux_quo != '0);
      end
    end else begin
      if (aux_quo <= {32'b0, cfg_i.rpm_limit}) begin
        res_rpm     = aux_quo[tach_pkg::RPM_W-1:0];
        res_present = (aux_quo != '0);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      tach_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          state_d = tach_pkg::BK_MUL_NUM;
        end
      end
      tach_pkg::BK_MUL_NUM: state_d = tach_pkg::BK_MUL_DEN;
      tach_pkg::BK_MUL_DEN: state_d = tach_pkg::BK_MUL_LIM;
      tach_pkg::BK_MUL_LIM: state_d = tach_pkg::BK_SCALE;
      tach_pkg::BK_SCALE:   state_d = tach_pkg::BK_START;
      tach_pkg::BK_START: begin
        div_start = 1'b1;
        state_d   = tach_pkg::BK_WAIT;
      end
      tach_pkg::BK_WAIT: begin
        if (aux_stat.done && freq_stat.done) state_d = tach_pkg::BK_FINISH;
      end
      tach_pkg::BK_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = tach_pkg::BK_IDLE;
        end
      end
      default: state_d = tach_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tach_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ch_q <= job_i.ch;
      p_q  <= job_i.period;
    end
    if (state_q == tach_pkg::BK_MUL_NUM) num_q <= num_prod;
    if (state_q == tach_pkg::BK_MUL_DEN) den_q <= den_prod;
    if (state_q == tach_pkg::BK_MUL_LIM) lim_q <= lim_prod;
    if (state_q == tach_pkg::BK_SCALE) begin
      num_s_q <= num_sc;
      den_s_q <= den_sc;
      over_q  <= ({19'b0, cfg_i.timer_clock_hz} > lim_q);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      channel_out_o           <= ch_q;
      signal_present_o        <= res_present;
      frequency_q8_o          <= res_freq;
      wheel_speed_centi_kph_o <= res_speed;
      engine_rpm_o            <= res_rpm;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/capture_period_tachometer.sv @@
// ----------------------------------------------------------------------------
// capture_period_tachometer
// Three-channel period tachometer with frequency, wheel speed and rpm.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a capture transfer (mode 0)
// updates the channel's period, last capture and edge time in the cycle it
// is taken and gives no result. A query transfer (mode 1) for a live
// channel becomes a job in a two-entry queue; silent channels, zero
// periods and channels out of range give no result.
// The back end takes one job at a time: three multiply steps, one scale
// step, then two 48-step restoring dividers side by side. A query passes
// the queue, these steps and the dividers before its result is loaded
// into the output register; a new job is taken only once that result is
// loaded. Captures are taken one per cycle while the queue has room.
// Output channel (out_valid_o / out_stall_i): the result waits in the
// output register while stalled; the back end already works on the next
// job and holds it until the register frees up; the queue then fills and
// in_stall_o rises.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register per
// cycle. Reset restores register defaults and clears all channel state.
// ----------------------------------------------------------------------------
module capture_period_tachometer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tach_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [tach_pkg::CH_W-1:0]         channel_i,
  input  logic [31:0]                       capture_value_i,
  input  logic [tach_pkg::MS_W-1:0]         now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tach_pkg::CH_W-1:0]         channel_out_o,
  output logic                              signal_present_o,
  output logic [tach_pkg::FREQ_W-1:0]       frequency_q8_o,
  output logic [tach_pkg::SPEED_W-1:0]      wheel_speed_centi_kph_o,
  output logic [tach_pkg::RPM_W-1:0]        engine_rpm_o
);

  tach_pkg::cfg_t  cfg_q;
  tach_pkg::job_t  push_job, pop_job;
  logic            push, pop, fifo_valid, fifo_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_clock_hz         <= tach_pkg::RST_TIMER_CLOCK_HZ;
      cfg_q.signal_timeout_ms      <= tach_pkg::RST_SIGNAL_TIMEOUT;
      cfg_q.wheel_hz_limit         <= tach_pkg::RST_WHEEL_HZ_LIMIT;
      cfg_q.wheel_teeth            <= tach_pkg::RST_WHEEL_TEETH;
      cfg_q.wheel_circumference_mm <= tach_pkg::RST_WHEEL_CIRC_MM;
      cfg_q.crank_pulses           <= tach_pkg::RST_ENGINE_PPR;
      cfg_q.rpm_limit              <= tach_pkg::RST_RPM_LIMIT;
    end else if (cfg_we_i) begin
      unique case (tach_pkg::cfg_idx_e'(cfg_idx_i))
        tach_pkg::CFG_TIMER_CLOCK_HZ:    cfg_q.timer_clock_hz <= cfg_data_i;
        tach_pkg::CFG_SIGNAL_TIMEOUT_MS: cfg_q.signal_timeout_ms <= cfg_data_i[15:0];
        tach_pkg::CFG_WHEEL_HZ_LIMIT:    cfg_q.wheel_hz_limit <= cfg_data_i[15:0];
        tach_pkg::CFG_WHEEL_TEETH:       cfg_q.wheel_teeth <= cfg_data_i[7:0];
        tach_pkg::CFG_WHEEL_CIRC_MM:     cfg_q.wheel_circumference_mm <= cfg_data_i[12:0];
        tach_pkg::CFG_ENGINE_PPR:        cfg_q.crank_pulses <= cfg_data_i[4:0];
        tach_pkg::CFG_RPM_LIMIT:         cfg_q.rpm_limit <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front end: channel state and query screening
  tach_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .channel_i       (channel_i),
    .capture_value_i (capture_value_i),
    .now_ms_i        (now_ms_i),
    .timeout_i       (cfg_q.signal_timeout_ms),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // job queue
  tach_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .valid_o (fifo_valid),
    .full_o  (fifo_full)
  );

  // back end: arithmetic and output register
  tach_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_i                   (cfg_q),
    .job_valid_i             (fifo_valid),
    .job_i                   (pop_job),
    .pop_o                   (pop),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .channel_out_o           (channel_out_o),
    .signal_present_o        (signal_present_o),
    .frequency_q8_o          (frequency_q8_o),
    .wheel_speed_centi_kph_o (wheel_speed_centi_kph_o),
    .engine_rpm_o            (engine_rpm_o)
  );

endmodule

@@ rtl/tach_checker.sv @@
// ----------------------------------------------------------------------------
// tach_checker
// Port-level checks of the capture period tachometer, bound to the top.
// ----------------------------------------------------------------------------
module tach_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [tach_pkg::CH_W-1:0]         channel_out_o,
  input logic                              signal_present_o,
  input logic [tach_pkg::FREQ_W-1:0]       frequency_q8_o,
  input logic [tach_pkg::SPEED_W-1:0]      wheel_speed_centi_kph_o,
  input logic [tach_pkg::RPM_W-1:0]        engine_rpm_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its readings
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(frequency_q8_o) &&
      $stable(wheel_speed_centi_kph_o) && $stable(engine_rpm_o))
    else $error("stalled result changed");

  // engine readings carry no wheel speed
  a_engine_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_out_o == tach_pkg::ENGINE_CH |-> wheel_speed_centi_kph_o == '0)
    else $error("wheel speed on engine channel");

  // wheel readings carry no rpm
  a_wheel_no_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_out_o != tach_pkg::ENGINE_CH |-> engine_rpm_o == '0)
    else $error("rpm on wheel channel");

  // a present wheel reading has a speed
  a_wheel_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_present_o && channel_out_o != tach_pkg::ENGINE_CH |->
      wheel_speed_centi_kph_o != '0)
    else $error("present wheel reading is zero");

endmodule

bind capture_period_tachometer tach_checker u_tach_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .out_valid_o             (out_valid_o),
  .out_stall_i             (out_stall_i),
  .channel_out_o           (channel_out_o),
  .signal_present_o        (signal_present_o),
  .frequency_q8_o          (frequency_q8_o),
  .wheel_speed_centi_kph_o (wheel_speed_centi_kph_o),
  .engine_rpm_o            (engine_rpm_o)
);

@@ sim/capture_period_tachometer_test.sv @@
// ----------------------------------------------------------------------------
// capture_period_tachometer_test
// Self-checking bench for the period tachometer. A short table of edge and
// query transfers covers the special cases. Random edge trains and queries
// then run under several register settings and idle patterns. Every reading
// is compared field by field with an independent integer predictor or a fixed table value.
// ----------------------------------------------------------------------------
module capture_period_tachometer_test;
  import tach_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int DRAIN_CYCLES     = 100;
  localparam int QUIET_LIMIT      = 20000;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 230;
  localparam int CFG_REGS         = 7;
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic [CH_W-1:0] LEFT_CH  = 2'd0;
  localparam logic [CH_W-1:0] RIGHT_CH = 2'd1;
  localparam logic [CH_W-1:0] NO_CH    = 2'd3;

  // how a table row is checked
  typedef enum {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_e;

  // register setting families
  typedef enum {SET_RANDOM, SET_ONES, SET_MIN, SET_RAW, SET_ZERO, SET_DEFAULT} cfg_set_e;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               present;
    logic [FREQ_W-1:0]  freq;
    logic [SPEED_W-1:0] speed;
    logic [RPM_W-1:0]   rpm;
  } reading_t;

  typedef struct {
    row_check_e       chk;
    mode_e            mode;
    logic [CH_W-1:0]  ch;
    logic [CAP_W-1:0] cap;
    logic [MS_W-1:0]  now;
    reading_t         want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  mode_i;
  logic [CH_W-1:0]       channel_i;
  logic [CAP_W-1:0]      capture_value_i;
  logic [MS_W-1:0]       now_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CH_W-1:0]       channel_out_o;
  logic                  signal_present_o;
  logic [FREQ_W-1:0]     frequency_q8_o;
  logic [SPEED_W-1:0]    wheel_speed_centi_kph_o;
  logic [RPM_W-1:0]      engine_rpm_o;

  // predictor state: register shadow and per-channel capture history
  cfg_t             live_cfg;
  logic [CAP_W-1:0] last_capture [CHANNELS];
  logic [31:0]      period_of    [CHANNELS];
  logic [MS_W-1:0]  edge_ms      [CHANNELS];

  // stimulus-side view of each channel's edge train
  logic [CAP_W-1:0] stim_cap  [4];
  logic [MS_W-1:0]  stim_edge [4];
  logic [MS_W-1:0]  stim_ms;

  reading_t  pending_readings [$];
  stim_row_t directed_rows    [$];
  int        fault_count  = 0;
  int        quiet_cycles = 0;
  int        idle_pct     = 0;
  int        stall_pct    = 0;

  capture_period_tachometer u_top (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .mode_i                  (mode_i),
    .channel_i               (channel_i),
    .capture_value_i         (capture_value_i),
    .now_ms_i                (now_ms_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .channel_out_o           (channel_out_o),
    .signal_present_o        (signal_present_o),
    .frequency_q8_o          (frequency_q8_o),
    .wheel_speed_centi_kph_o (wheel_speed_centi_kph_o),
    .engine_rpm_o            (engine_rpm_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // edge or query update; returns 1 when a reading comes out
  function automatic bit compute_reading(input mode_e mode, input logic [CH_W-1:0] ch,
                                         input logic [CAP_W-1:0] cap,
                                         input logic [MS_W-1:0] now, output reading_t r);
    logic [63:0] clk64, p, freq, speed, rpm, div, lim, circ, rpm_max;
    logic [31:0] elapsed;
    r = '0;
    if (ch >= CHANNELS) return 0;
    if (mode == MODE_CAPTURE) begin
      if (last_capture[ch] != 0) period_of[ch] = cap - last_capture[ch];
      last_capture[ch] = cap;
      edge_ms[ch] = now;
      return 0;
    end
    elapsed = now - edge_ms[ch];
    p = period_of[ch];
    if (elapsed > live_cfg.signal_timeout_ms || p == 0) return 0;
    clk64 = live_cfg.timer_clock_hz;
    freq = (clk64 << 8) / p;
    speed = 0;
    rpm = 0;
    r.ch = ch;
    if (ch != ENGINE_CH) begin
      div = (live_cfg.wheel_teeth == 0) ? 64'd1 : {56'd0, live_cfg.wheel_teeth};
      lim = live_cfg.wheel_hz_limit;
      lim = lim * p;
      circ = live_cfg.wheel_circumference_mm;
      if (clk64 > lim) begin
        freq = 0;
        r.present = 1'b0;
      end else begin
        speed = (clk64 * circ * 64'd9) / (p * div * 64'd25);
        r.present = (speed != 0);
      end
    end else begin
      div = (live_cfg.crank_pulses == 0) ? 64'd1
                                         : {59'd0, live_cfg.crank_pulses};
      rpm_max = live_cfg.rpm_limit;
      rpm = (clk64 * 64'd60) / (p * div);
      if (rpm > rpm_max) begin
        rpm = 0;
        r.present = 1'b0;
      end else begin
        r.present = (rpm != 0);
      end
    end
    r.freq  = freq[FREQ_W-1:0];
    r.speed = speed[SPEED_W-1:0];
    r.rpm   = rpm[RPM_W-1:0];
    return 1;
  endfunction

  task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
    fault_count++;
    if (fault_count <= SHOWN_MISMATCHES)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) note_fault(what, want, got);
  endtask

  // compare one output transfer with the oldest pending reading
  task automatic take_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      note_fault("reading with none pending on channel", 0, channel_out_o);
    end else begin
      want = pending_readings.pop_front();
      check_field("channel_out", want.ch, channel_out_o);
      check_field("signal_present", want.present, signal_present_o);
      check_field("frequency_q8", want.freq, frequency_q8_o);
      check_field("wheel_speed_centi_kph", want.speed, wheel_speed_centi_kph_o);
      check_field("engine_rpm", want.rpm, engine_rpm_o);
    end
  endtask

  // output side: check transfers, stall at random
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) take_reading();
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("capture_period_tachometer_test: errors");
    $finish;
  end

  // one register write, mirrored in the shadow
  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TIMER_CLOCK_HZ:    live_cfg.timer_clock_hz         = data[28:0];
      CFG_SIGNAL_TIMEOUT_MS: live_cfg.signal_timeout_ms      = data[15:0];
      CFG_WHEEL_HZ_LIMIT:    live_cfg.wheel_hz_limit         = data[15:0];
      CFG_WHEEL_TEETH:       live_cfg.wheel_teeth            = data[7:0];
      CFG_WHEEL_CIRC_MM:     live_cfg.wheel_circumference_mm = data[12:0];
      CFG_ENGINE_PPR:        live_cfg.crank_pulses           = data[4:0];
      CFG_RPM_LIMIT:         live_cfg.rpm_limit              = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] setting_for(input cfg_set_e kind,
                                                         input cfg_idx_e idx);
    case (kind)
      SET_ONES:    return '1;
      SET_MIN:     return 1;
      SET_ZERO:    return 0;
      SET_RAW:     return $urandom;
      SET_DEFAULT: begin
        case (idx)
          CFG_TIMER_CLOCK_HZ:    return RST_TIMER_CLOCK_HZ;
          CFG_SIGNAL_TIMEOUT_MS: return RST_SIGNAL_TIMEOUT;
          CFG_WHEEL_HZ_LIMIT:    return RST_WHEEL_HZ_LIMIT;
          CFG_WHEEL_TEETH:       return RST_WHEEL_TEETH;
          CFG_WHEEL_CIRC_MM:     return RST_WHEEL_CIRC_MM;
          CFG_ENGINE_PPR:        return RST_ENGINE_PPR;
          default:               return RST_RPM_LIMIT;
        endcase
      end
      default: begin
        case (idx)
          CFG_TIMER_CLOCK_HZ:    return $urandom_range(200000000, 1000);
          CFG_SIGNAL_TIMEOUT_MS: return $urandom_range(2000, 0);
          CFG_WHEEL_HZ_LIMIT:    return $urandom_range(65535, 1);
          CFG_WHEEL_TEETH:       return $urandom_range(255, 1);
          CFG_WHEEL_CIRC_MM:     return $urandom_range(8191, 1);
          CFG_ENGINE_PPR:        return $urandom_range(16, 1);
          default:               return $urandom_range(65535, 1);
        endcase
      end
    endcase
  endfunction

  task automatic apply_settings(input cfg_set_e kind);
    for (int i = 0; i < CFG_REGS; i++) put_reg(cfg_idx_e'(i), setting_for(kind, cfg_idx_e'(i)));
    cfg_we_i <= 1'b0;
  endtask

  // let every pending reading drain, then the back end settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // present one input transfer, record what it should produce, then maybe idle
  task automatic drive_item(input stim_row_t row);
    reading_t r;
    bit       got;
    in_valid_i      <= 1'b1;
    mode_i          <= row.mode;
    channel_i       <= row.ch;
    capture_value_i <= row.cap;
    now_ms_i        <= row.now;
    do @(posedge clk_i); while (in_stall_o);
    got = compute_reading(row.mode, row.ch, row.cap, row.now, r);
    case (row.chk)
      CHK_MODEL: if (got) pending_readings.push_back(r);
      CHK_FIXED: pending_readings.push_back(row.want);
      default: ;
    endcase
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic add_row(input row_check_e chk, input mode_e mode, input logic [CH_W-1:0] ch,
                         input logic [CAP_W-1:0] cap, input logic [MS_W-1:0] now,
                         input logic present, input logic [FREQ_W-1:0] freq,
                         input logic [SPEED_W-1:0] speed, input logic [RPM_W-1:0] rpm);
    stim_row_t row;
    row.chk          = chk;
    row.mode         = mode;
    row.ch           = ch;
    row.cap          = cap;
    row.now          = now;
    row.want.ch      = ch;
    row.want.present = present;
    row.want.freq    = freq;
    row.want.speed   = speed;
    row.want.rpm     = rpm;
    directed_rows.push_back(row);
  endtask

  // random edge trains with periods near the useful range, plus noise
  task automatic roll_item(output stim_row_t row);
    int          pick;
    int          hz_top;
    logic [63:0] clk64, span, ppr_eff, rpm_max;
    logic [31:0] delta;
    row.chk  = CHK_MODEL;
    row.want = '0;
    row.ch   = $urandom_range(2, 0);
    if ($urandom_range(19, 0) == 0) row.ch = NO_CH;
    row.mode = ($urandom_range(1, 0) == 0) ? MODE_CAPTURE : MODE_QUERY;
    if (row.mode == MODE_CAPTURE) begin
      clk64 = live_cfg.timer_clock_hz;
      if (row.ch == ENGINE_CH) begin
        ppr_eff = (live_cfg.crank_pulses == 0) ? 64'd1
                                               : {59'd0, live_cfg.crank_pulses};
        rpm_max = live_cfg.rpm_limit;
        hz_top = ppr_eff * rpm_max / 64'd60 + 64'd2;
      end else begin
        hz_top = live_cfg.wheel_hz_limit + live_cfg.wheel_hz_limit / 8 + 1;
      end
      pick = $urandom_range(9, 0);
      delta = 0;
      if (pick < 7) begin
        span = clk64 / $urandom_range(hz_top, 1);
        if (span == 0) span = $urandom_range(4, 1);
        delta = span[31:0];
      end else if (pick == 7) begin
        delta = $urandom;
      end
      row.cap = (pick == 9) ? $urandom : stim_cap[row.ch] + delta;
      if ($urandom_range(39, 0) == 0) row.cap = 0;
      if ($urandom_range(29, 0) == 0) stim_ms = $urandom;
      else stim_ms = stim_ms + $urandom_range(15, 0);
      row.now = stim_ms;
      stim_cap[row.ch]  = row.cap;
      stim_edge[row.ch] = stim_ms;
    end else begin
      row.cap = $urandom;
      pick = $urandom_range(9, 0);
      if (pick < 8) row.now = stim_edge[row.ch] +
                              $urandom_range(live_cfg.signal_timeout_ms + 2, 0);
      else if (pick == 8) row.now = stim_ms;
      else row.now = $urandom;
    end
  endtask

  // directed table; fixed readings assume reset settings
  initial begin
    add_row(CHK_NONE,  MODE_QUERY,   LEFT_CH,   0,            0,            0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, LEFT_CH,   0,            0,            0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, LEFT_CH,   1000,         0,            0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, LEFT_CH,   97000,        10,           0, 0, 0, 0);
    add_row(CHK_FIXED, MODE_QUERY,   LEFT_CH,   0,            10,           1, 256000, 28800, 0);
    // exactly at the timeout, then one past it
    add_row(CHK_FIXED, MODE_QUERY,   LEFT_CH,   '1,           510,          1, 256000, 28800, 0);
    add_row(CHK_NONE,  MODE_QUERY,   LEFT_CH,   0,            511,          0, 0, 0, 0);
    // repeated capture gives a zero period
    add_row(CHK_MODEL, MODE_CAPTURE, LEFT_CH,   97000,        20,           0, 0, 0, 0);
    add_row(CHK_NONE,  MODE_QUERY,   LEFT_CH,   0,            20,           0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, LEFT_CH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_QUERY,   LEFT_CH,   0,            32'hFFFF_FFFF, 0, 0, 0, 0);
    // counter wrap, then a wheel above its frequency limit
    add_row(CHK_MODEL, MODE_CAPTURE, RIGHT_CH,  32'hFFFF_FFF0, 100,         0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, RIGHT_CH,  32'h0000_0010, 100,         0, 0, 0, 0);
    add_row(CHK_FIXED, MODE_QUERY,   RIGHT_CH,  0,            100,          0, 0, 0, 0);
    // engine at the rpm limit across a millisecond wrap
    add_row(CHK_MODEL, MODE_CAPTURE, ENGINE_CH, 5,            32'hFFFF_FF00, 0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_CAPTURE, ENGINE_CH, 288005,       32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(CHK_FIXED, MODE_QUERY,   ENGINE_CH, 0,            32'h0000_01F3, 1, 85333, 0, 20000);
    add_row(CHK_NONE,  MODE_QUERY,   ENGINE_CH, 0,            32'h0000_01F4, 0, 0, 0, 0);
    // engine just above the rpm limit
    add_row(CHK_MODEL, MODE_CAPTURE, ENGINE_CH, 575005,       32'h0000_01F4, 0, 0, 0, 0);
    add_row(CHK_MODEL, MODE_QUERY,   ENGINE_CH, 0,            32'h0000_01F4, 0, 0, 0, 0);
    // channel out of range is ignored, and a long-silent channel gives no reading
    add_row(CHK_NONE,  MODE_CAPTURE, NO_CH,     12345,        0,            0, 0, 0, 0);
    add_row(CHK_NONE,  MODE_QUERY,   NO_CH,     0,            0,            0, 0, 0, 0);
    add_row(CHK_NONE,  MODE_QUERY,   RIGHT_CH,  0,            32'h8000_0000, 0, 0, 0, 0);
  end

  // reset, directed table, then random phases
  initial begin
    stim_row_t row;
    int        sent;
    cfg_set_e  kind;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    mode_i          = 1'b0;
    channel_i       = '0;
    capture_value_i = '0;
    now_ms_i        = '0;
    stim_ms         = '0;
    live_cfg.timer_clock_hz         = RST_TIMER_CLOCK_HZ;
    live_cfg.signal_timeout_ms      = RST_SIGNAL_TIMEOUT;
    live_cfg.wheel_hz_limit         = RST_WHEEL_HZ_LIMIT;
    live_cfg.wheel_teeth            = RST_WHEEL_TEETH;
    live_cfg.wheel_circumference_mm = RST_WHEEL_CIRC_MM;
    live_cfg.crank_pulses           = RST_ENGINE_PPR;
    live_cfg.rpm_limit              = RST_RPM_LIMIT;
    for (int c = 0; c < CHANNELS; c++) begin
      last_capture[c] = '0;
      period_of[c]    = '0;
      edge_ms[c]      = '0;
    end
    for (int c = 0; c < 4; c++) begin
      stim_cap[c]  = '0;
      stim_edge[c] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed_rows.size(); i++) drive_item(directed_rows[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1:       kind = SET_ONES;
        3:       kind = SET_MIN;
        4:       kind = SET_RAW;
        5:       kind = SET_ZERO;
        7:       kind = SET_DEFAULT;
        default: kind = SET_RANDOM;
      endcase
      apply_settings(kind);
      // no idling, sender idle, receiver stalling, both
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 66; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll_item(row);
        drive_item(row);
        if (row.ch < CHANNELS) sent++;
      end
    end

    wait_idle();
    if (fault_count == 0) begin
      $display("capture_period_tachometer_test: clean");
    end else begin
      $display("capture_period_tachometer_test: errors");
    end
    $finish;
  end

endmodule
